>>> src/trs_pkg.sv
// shared constants, types and arithmetic helpers for the trs model matrix core
// no dependencies; used by every module under src
package trs_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 30;
   localparam int ANG_W        = 34;   // cordic angle accumulator, binary angle units
   localparam int XY_W         = 34;   // cordic x / y datapath
   localparam int TRIG_W       = 33;   // q2.30 sine and cosine
   localparam int ROT_W        = 34;   // rotation element before scaling
   localparam int PROD_W       = 66;   // rotation element times scale

   // one full turn in input units and the offset that makes any 32-bit angle non-negative
   localparam logic [32:0] TURN       = 33'(360) << FRAC_BITS;
   localparam logic [32:0] ANG_OFFSET = 33'(((64'd1 << 31) / TURN) + 1) * TURN;

   // reciprocal constants (floor forms need one correction step, ceil form is exact)
   localparam logic [13:0] RECIP_360 = 14'((64'd1 << 22) / 360);
   localparam logic [25:0] RECIP_45  = 26'((64'd1 << 31) / 45);
   localparam logic [19:0] RECIP_45C = 20'(((64'd1 << 25) + 44) / 45);

   localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [PROD_W-1:0] Q30_HALF  = 66'sd536870912;

   typedef struct packed {
      logic signed [ANG_W-1:0] z;
      logic                    flip;
   } ang_type;

   function automatic logic signed [ANG_W-1:0] atan_turn(input logic [4:0] idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         5'd0:  v = 34'sd536870912;
         5'd1:  v = 34'sd316933406;
         5'd2:  v = 34'sd167458907;
         5'd3:  v = 34'sd85004756;
         5'd4:  v = 34'sd42667331;
         5'd5:  v = 34'sd21354465;
         5'd6:  v = 34'sd10679838;
         5'd7:  v = 34'sd5340245;
         5'd8:  v = 34'sd2670163;
         5'd9:  v = 34'sd1335087;
         5'd10: v = 34'sd667544;
         5'd11: v = 34'sd333772;
         5'd12: v = 34'sd166886;
         5'd13: v = 34'sd83443;
         5'd14: v = 34'sd41722;
         5'd15: v = 34'sd20861;
         5'd16: v = 34'sd10430;
         5'd17: v = 34'sd5215;
         5'd18: v = 34'sd2608;
         5'd19: v = 34'sd1304;
         5'd20: v = 34'sd652;
         5'd21: v = 34'sd326;
         5'd22: v = 34'sd163;
         5'd23: v = 34'sd81;
         5'd24: v = 34'sd41;
         5'd25: v = 34'sd20;
         5'd26: v = 34'sd10;
         5'd27: v = 34'sd5;
         5'd28: v = 34'sd3;
         5'd29: v = 34'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   // q30 times q30, rounded half up back to q30
   function automatic logic signed [ROT_W-1:0] mul30(input logic signed [TRIG_W-1:0] a,
                                                     input logic signed [TRIG_W-1:0] b);
      logic signed [PROD_W-1:0] p;
      p = a * b;
      p = p + Q30_HALF;
      return ROT_W'(p >>> 30);
   endfunction

   // round a scaled product back to q16.16 and clamp to 32 bits
   function automatic logic [31:0] round_sat(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] q;
      q = (p + Q30_HALF) >>> 30;
      if (q > 66'sd2147483647) return 32'h7fff_ffff;
      if (q < -66'sd2147483648) return 32'h8000_0000;
      return q[31:0];
   endfunction

endpackage

>>> src/trs_angle.sv
// angle reduction modulo 360, conversion to binary angle and quadrant fold
// depends on trs_pkg; five register stages
module trs_angle (
   input  logic                 clock,
   input  logic                 advance,
   input  logic [31:0]          angle,
   output trs_pkg::ang_type     ang_out
);

   logic [32:0] s1_shift_ff, s1_shift_in;
   logic [7:0]  s1_quot_ff, s1_quot_in;
   logic [30:0] s1_prod;
   logic [24:0] s2_rem_ff, s2_rem_in;
   logic [32:0] s2_diff;
   logic [24:0] s3_rem_ff;
   logic [19:0] s3_quot_ff, s3_quot_in;
   logic [50:0] s3_prod;
   logic [19:0] s4_hi_ff, s4_hi_in;
   logic [5:0]  s4_lo_ff, s4_lo_in;
   logic [24:0] s4_diff;
   logic [25:0] s5_prod;
   logic [31:0] s5_phase;
   trs_pkg::ang_type ang_ff, ang_in;

   always_comb begin
      s1_shift_in = {angle[31], angle} + trs_pkg::ANG_OFFSET;
      s1_prod     = 31'(s1_shift_in[32:16]) * 31'(trs_pkg::RECIP_360);
      s1_quot_in  = s1_prod[29:22];

      s2_diff   = s1_shift_ff - 33'(s1_quot_ff) * trs_pkg::TURN;
      s2_rem_in = (s2_diff >= trs_pkg::TURN) ? 25'(s2_diff - trs_pkg::TURN) : s2_diff[24:0];

      s3_prod    = 51'(s2_rem_ff) * 51'(trs_pkg::RECIP_45);
      s3_quot_in = s3_prod[50:31];

      // r = 45 * hi + lo, phase = 8192 * hi + floor(8192 * lo / 45)
      s4_diff = s3_rem_ff - 25'(s3_quot_ff) * 25'd45;
      if (s4_diff >= 25'd45) begin
         s4_hi_in = s3_quot_ff + 20'd1;
         s4_lo_in = 6'(s4_diff - 25'd45);
      end else begin
         s4_hi_in = s3_quot_ff;
         s4_lo_in = s4_diff[5:0];
      end

      s5_prod     = 26'(s4_lo_ff) * 26'(trs_pkg::RECIP_45C);
      s5_phase    = {s4_hi_ff[18:0], 13'b0} + {18'b0, s5_prod[25:12]};
      // second and third quadrant: rotate by half a turn, negate later
      ang_in.flip = s5_phase[31] ^ s5_phase[30];
      ang_in.z    = {{2{s5_phase[30]}}, s5_phase[30], s5_phase[30:0]};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_shift_ff <= s1_shift_in;
         s1_quot_ff  <= s1_quot_in;
         s2_rem_ff   <= s2_rem_in;
         s3_rem_ff   <= s2_rem_ff;
         s3_quot_ff  <= s3_quot_in;
         s4_hi_ff    <= s4_hi_in;
         s4_lo_ff    <= s4_lo_in;
         ang_ff      <= ang_in;
      end
   end

   assign ang_out = ang_ff;

endmodule

>>> src/trs_cordic.sv
// fully pipelined rotation-mode cordic, one iteration per stage, plus a sign stage
// depends on trs_pkg
module trs_cordic (
   input  logic                                clock,
   input  logic                                advance,
   input  trs_pkg::ang_type                    ang_in,
   output logic signed [trs_pkg::TRIG_W-1:0]   sin_out,
   output logic signed [trs_pkg::TRIG_W-1:0]   cos_out
);

   localparam int N = trs_pkg::CORDIC_STEPS;

   logic signed [trs_pkg::XY_W-1:0]  x_ff [1:N];
   logic signed [trs_pkg::XY_W-1:0]  y_ff [1:N];
   logic signed [trs_pkg::ANG_W-1:0] z_ff [1:N-1];
   logic                             flip_ff [1:N];
   logic signed [trs_pkg::TRIG_W-1:0] sin_ff, sin_in, cos_ff, cos_in;

   for (genvar i = 0; i < N; i++) begin : g_step
      logic signed [trs_pkg::XY_W-1:0]  x_cur, y_cur, x_in, y_in;
      logic signed [trs_pkg::ANG_W-1:0] z_cur;
      logic                             flip_cur;

      // the first iteration starts from the gain on x and the folded angle
      if (i == 0) begin : g_first
         assign x_cur    = trs_pkg::CORDIC_GAIN;
         assign y_cur    = '0;
         assign z_cur    = ang_in.z;
         assign flip_cur = ang_in.flip;
      end else begin : g_next
         assign x_cur    = x_ff[i];
         assign y_cur    = y_ff[i];
         assign z_cur    = z_ff[i];
         assign flip_cur = flip_ff[i];
      end

      always_comb begin
         if (!z_cur[trs_pkg::ANG_W-1]) begin
            x_in = x_cur - (y_cur >>> i);
            y_in = y_cur + (x_cur >>> i);
         end else begin
            x_in = x_cur + (y_cur >>> i);
            y_in = y_cur - (x_cur >>> i);
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            flip_ff[i+1] <= flip_cur;
         end
      end

      // the residual angle after the last iteration is not needed
      if (i < N - 1) begin : g_angle
         logic signed [trs_pkg::ANG_W-1:0] z_in;
         assign z_in = z_cur[trs_pkg::ANG_W-1] ? z_cur + trs_pkg::atan_turn(5'(i))
                                               : z_cur - trs_pkg::atan_turn(5'(i));
         always_ff @(posedge clock) begin
            if (advance) begin
               z_ff[i+1] <= z_in;
            end
         end
      end
   end

   always_comb begin
      sin_in = flip_ff[N] ? -trs_pkg::TRIG_W'(y_ff[N]) : trs_pkg::TRIG_W'(y_ff[N]);
      cos_in = flip_ff[N] ? -trs_pkg::TRIG_W'(x_ff[N]) : trs_pkg::TRIG_W'(x_ff[N]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

>>> src/trs_matrix.sv
// rotation products, sums, scaling and saturation of the nine matrix elements
// depends on trs_pkg; five register stages, the last is the output register
module trs_matrix (
   input  logic                               clock,
   input  logic                               advance,
   input  logic signed [trs_pkg::TRIG_W-1:0]  sx,
   input  logic signed [trs_pkg::TRIG_W-1:0]  cx,
   input  logic signed [trs_pkg::TRIG_W-1:0]  sy,
   input  logic signed [trs_pkg::TRIG_W-1:0]  cy,
   input  logic signed [trs_pkg::TRIG_W-1:0]  sz,
   input  logic signed [trs_pkg::TRIG_W-1:0]  cz,
   input  logic [95:0]                        scale,  // scale_x, scale_y, scale_z
   input  logic [95:0]                        pos,    // pos_x, pos_y, pos_z
   output logic [383:0]                       result  // row0_col0 .. row2_col2, trans_x..z
);

   localparam int RW = trs_pkg::ROT_W;
   localparam int TW = trs_pkg::TRIG_W;

   // stage 1: first-level products
   logic signed [RW-1:0] t_ff, u_ff, cycz_ff, cysz_ff, sycx_ff, cxsz_ff, cxcz_ff;
   logic signed [RW-1:0] sycz_ff, sysz_ff, cycx_ff;
   logic signed [TW-1:0] s1_sx_ff, s1_sz_ff, s1_cz_ff;
   // stage 2: products that reuse t and u
   logic signed [RW-1:0] tsz_ff, tcz_ff, usz_ff, ucz_ff;
   logic signed [RW-1:0] s2_cycz_ff, s2_cysz_ff, s2_sycx_ff, s2_cxsz_ff, s2_cxcz_ff;
   logic signed [RW-1:0] s2_sycz_ff, s2_sysz_ff, s2_cycx_ff;
   logic signed [TW-1:0] s2_sx_ff;
   // stage 3: rotation elements
   logic signed [RW-1:0] rot_ff [0:8];
   logic signed [RW-1:0] rot_in [0:8];
   // stage 4: scaled products
   logic signed [trs_pkg::PROD_W-1:0] prod_ff [0:8];
   // stage 5: output
   logic [383:0] result_ff, result_in;
   logic [95:0]  pos_ff [1:4];
   logic [95:0]  scale_ff [1:3];

   always_comb begin
      rot_in[0] = s2_cycz_ff + tsz_ff;
      rot_in[1] = tcz_ff - s2_cysz_ff;
      rot_in[2] = s2_sycx_ff;
      rot_in[3] = s2_cxsz_ff;
      rot_in[4] = s2_cxcz_ff;
      rot_in[5] = -RW'(s2_sx_ff);
      rot_in[6] = usz_ff - s2_sycz_ff;
      rot_in[7] = s2_sysz_ff + ucz_ff;
      rot_in[8] = s2_cycx_ff;
      for (int i = 0; i < 9; i++) begin
         result_in[32*i +: 32] = trs_pkg::round_sat(prod_ff[i]);
      end
      result_in[383:288] = pos_ff[4];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t_ff     <= trs_pkg::mul30(sy, sx);
         u_ff     <= trs_pkg::mul30(cy, sx);
         cycz_ff  <= trs_pkg::mul30(cy, cz);
         cysz_ff  <= trs_pkg::mul30(cy, sz);
         sycx_ff  <= trs_pkg::mul30(sy, cx);
         cxsz_ff  <= trs_pkg::mul30(cx, sz);
         cxcz_ff  <= trs_pkg::mul30(cx, cz);
         sycz_ff  <= trs_pkg::mul30(sy, cz);
         sysz_ff  <= trs_pkg::mul30(sy, sz);
         cycx_ff  <= trs_pkg::mul30(cy, cx);
         s1_sx_ff <= sx;
         s1_sz_ff <= sz;
         s1_cz_ff <= cz;

         tsz_ff     <= trs_pkg::mul30(TW'(t_ff), s1_sz_ff);
         tcz_ff     <= trs_pkg::mul30(TW'(t_ff), s1_cz_ff);
         usz_ff     <= trs_pkg::mul30(TW'(u_ff), s1_sz_ff);
         ucz_ff     <= trs_pkg::mul30(TW'(u_ff), s1_cz_ff);
         s2_cycz_ff <= cycz_ff;
         s2_cysz_ff <= cysz_ff;
         s2_sycx_ff <= sycx_ff;
         s2_cxsz_ff <= cxsz_ff;
         s2_cxcz_ff <= cxcz_ff;
         s2_sycz_ff <= sycz_ff;
         s2_sysz_ff <= sysz_ff;
         s2_cycx_ff <= cycx_ff;
         s2_sx_ff   <= s1_sx_ff;

         for (int i = 0; i < 9; i++) begin
            rot_ff[i]  <= rot_in[i];
            prod_ff[i] <= rot_ff[i] * $signed(scale_ff[3][32*(i%3) +: 32]);
         end

         pos_ff[1]   <= pos;
         scale_ff[1] <= scale;
         for (int k = 2; k <= 4; k++) pos_ff[k] <= pos_ff[k-1];
         for (int k = 2; k <= 3; k++) scale_ff[k] <= scale_ff[k-1];

         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

>>> src/trs_model_matrix_core.sv
// top level of the trs model matrix core: streaming ports, valid tracking, input delay line
// depends on trs_pkg, trs_angle, trs_cordic and trs_matrix
//
// Builds the upper three rows of the affine model matrix T * Ry * Rx * Rz * S from a
// position, three Euler angles in degrees and three scale factors, all signed q16.16.
// One transaction is accepted every cycle while the pipeline is not held, and each
// yields exactly one result transaction after angle reduction, cordic (30 unrolled
// iterations plus a sign stage, three units in parallel, one per axis) and products,
// scaling and saturation. The whole pipeline advances together; it holds while a result
// sits in the output register and rsp_tready is low, and req_tready follows that.
// The translation column is passed through unchanged; matrix elements saturate to 32 bits.
module trs_model_matrix_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, pos_z, angle_x_deg, angle_y_deg, angle_z_deg, scale_x, scale_y, scale_z
   input  logic [287:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // row0_col0, row0_col1, row0_col2, row1_col0 .. row2_col2, trans_x, trans_y, trans_z
   output logic [383:0] rsp_tdata
);

   localparam int FRONT = 5 + trs_pkg::CORDIC_STEPS + 1;   // register stages ahead of the matrix stages
   localparam int LAT   = FRONT + 5;

   logic advance;
   logic [LAT-1:0] vld_ff, vld_in;

   // pos and scale wait here while the trig values are made
   logic [191:0] pay_ff [0:FRONT-1];

   trs_pkg::ang_type ang [0:2];
   logic signed [trs_pkg::TRIG_W-1:0] sin_v [0:2];
   logic signed [trs_pkg::TRIG_W-1:0] cos_v [0:2];

   // the whole pipe moves unless the output register is full and stalled
   assign advance    = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = vld_ff[LAT-1];

   assign vld_in = {vld_ff[LAT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pay_ff[0] <= {req_tdata[287:192], req_tdata[95:0]};
         for (int k = 1; k < FRONT; k++) pay_ff[k] <= pay_ff[k-1];
      end
   end

   // one angle lane per axis: x, y, z
   for (genvar a = 0; a < 3; a++) begin : g_axis
      trs_angle u_angle (
         .clock   (clock),
         .advance (advance),
         .angle   (req_tdata[96 + 32*a +: 32]),
         .ang_out (ang[a])
      );
      trs_cordic u_cordic (
         .clock   (clock),
         .advance (advance),
         .ang_in  (ang[a]),
         .sin_out (sin_v[a]),
         .cos_out (cos_v[a])
      );
   end

   trs_matrix u_matrix (
      .clock   (clock),
      .advance (advance),
      .sx      (sin_v[0]),
      .cx      (cos_v[0]),
      .sy      (sin_v[1]),
      .cy      (cos_v[1]),
      .sz      (sin_v[2]),
      .cz      (cos_v[2]),
      .scale   (pay_ff[FRONT-1][191:96]),
      .pos     (pay_ff[FRONT-1][95:0]),
      .result  (rsp_tdata)
   );

endmodule
